// File: hw/rtl/mprd_pkg.sv
// ----------------------------------------------------------------------------
// mprd_pkg
// Types, codes and constants shared by the meter poll response decoder.
// ----------------------------------------------------------------------------
package mprd_pkg;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int QUERY_W   = 3;
    localparam int CHANNEL_W = 2;
    localparam int VALUE_W   = 38;
    localparam int SCALE_W   = 16;
    localparam int RETRY_W   = 2;
    localparam int COUNT_W   = 5;
    localparam int FAIL_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int RAW_W     = 22;
    localparam int DATA_DEPTH = 12;
    localparam int DATA_IDX_W = 4;

    localparam int JOB_QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] DATA_FIRST = 5'd14;
    localparam logic [COUNT_W-1:0] DATA_LAST  = 5'd25;

    // Input operations
    localparam logic [OP_W-1:0] OP_START   = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE    = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FAILED  = 2'd3;

    // Queries
    localparam logic [QUERY_W-1:0] QUERY_VOLTAGE = 3'd0;
    localparam logic [QUERY_W-1:0] QUERY_CURRENT = 3'd1;
    localparam logic [QUERY_W-1:0] QUERY_PF      = 3'd5;
    localparam logic [QUERY_W-1:0] QUERY_IDLE    = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 1'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd300;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 2'd1;

    // Job kinds passed from front to back
    localparam logic [1:0] JOB_REQUEST = 2'd0;
    localparam logic [1:0] JOB_FRAME   = 2'd1;
    localparam logic [1:0] JOB_FAIL    = 2'd2;

    typedef logic [DATA_DEPTH-1:0][BYTE_W-1:0] data_t;

    typedef struct packed {
        logic [1:0]         jkind;
        logic [QUERY_W-1:0] query;
        data_t              data;
    } job_t;

    typedef struct packed {
        logic [SCALE_W-1:0] current_scale;
        logic [RETRY_W-1:0] retry_limit;
    } cfg_t;

    function automatic logic [COUNT_W-1:0] frame_len(input logic [QUERY_W-1:0] q);
        logic [COUNT_W-1:0] len;
        case (q)
            3'd0:    len = 5'd22;
            3'd1:    len = 5'd25;
            3'd2:    len = 5'd28;
            3'd3:    len = 5'd28;
            3'd4:    len = 5'd28;
            3'd5:    len = 5'd24;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // One byte read as two offset digits: 10*(hi-3) + (lo-3).
    function automatic logic signed [RAW_W-1:0] byte_digit(input logic [BYTE_W-1:0] b);
        logic [RAW_W-1:0] hi;
        logic [RAW_W-1:0] lo;
        hi = {{(RAW_W-4){1'b0}}, b[7:4]};
        lo = {{(RAW_W-4){1'b0}}, b[3:0]};
        return $signed(hi * RAW_W'(10) + lo - RAW_W'(33));
    endfunction

endpackage

// File: hw/rtl/mprd_item_if.sv
// ----------------------------------------------------------------------------
// mprd_item_if
// Input channel: poll commands, received bytes and timeouts.
// ----------------------------------------------------------------------------
interface mprd_item_if import mprd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// File: hw/rtl/mprd_result_if.sv
// ----------------------------------------------------------------------------
// mprd_result_if
// Output channel: requests, measured values and cycle status.
// ----------------------------------------------------------------------------
interface mprd_result_if import mprd_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic [QUERY_W-1:0]          query;
    logic [CHANNEL_W-1:0]        channel;
    logic signed [VALUE_W-1:0]   value;
    logic                        last;

    modport source (output valid, output kind, output query, output channel,
                    output value, output last, input ready);
    modport sink   (input valid, input kind, input query, input channel,
                    input value, input last, output ready);
endinterface

// File: hw/rtl/mprd_cfg_if.sv
// ----------------------------------------------------------------------------
// mprd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mprd_cfg_if import mprd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/mprd_front.sv
// ----------------------------------------------------------------------------
// mprd_front
// Accepts items, tracks the poll sequence and frame byte count, keeps the
// data bytes of the frame and hands at most one job per item to the queue.
// ----------------------------------------------------------------------------
module mprd_front import mprd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mprd_item_if.sink    item,
    input  cfg_t         cfg,
    output logic         job_valid,
    input  logic         job_ready,
    output job_t         job
);

    logic [QUERY_W-1:0]    active_reg, active_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [FAIL_W-1:0]     fail_reg, fail_next;
    data_t                 data_reg, data_next;
    logic                  accept;
    logic [COUNT_W-1:0]    count_inc;
    logic [COUNT_W-1:0]    offset;
    logic [DATA_IDX_W-1:0] wr_idx;

    assign item.ready = job_ready;
    assign accept     = item.valid && item.ready;
    assign count_inc  = count_reg + COUNT_W'(1);
    assign offset     = count_reg - DATA_FIRST;
    assign wr_idx     = offset[DATA_IDX_W-1:0];

    always_comb
    begin
        active_next = active_reg;
        count_next  = count_reg;
        fail_next   = fail_reg;
        data_next   = data_reg;
        job_valid   = 1'b0;
        job.jkind   = JOB_REQUEST;
        job.query   = active_reg;
        job.data    = data_reg;
        if (accept)
        begin
            case (item.op)
                OP_START:
                begin
                    active_next = QUERY_VOLTAGE;
                    count_next  = '0;
                    job_valid   = 1'b1;
                    job.query   = QUERY_VOLTAGE;
                end
                OP_BYTE:
                begin
                    if (active_reg <= QUERY_PF)
                    begin
                        if (count_reg inside {[DATA_FIRST:DATA_LAST]})
                        begin
                            data_next[wr_idx] = item.rx_byte;
                        end
                        if (count_inc == frame_len(active_reg))
                        begin
                            count_next = '0;
                            fail_next  = '0;
                            job_valid  = 1'b1;
                            job.jkind  = JOB_FRAME;
                            // If the last byte of the frame is a data byte, it is merged in here.
                            job.data   = data_next;
                            active_next = (active_reg == QUERY_PF) ? QUERY_IDLE
                                                                   : active_reg + QUERY_W'(1);
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                    end
                end
                OP_TIMEOUT:
                begin
                    if (active_reg <= QUERY_PF)
                    begin
                        count_next = '0;
                        job_valid  = 1'b1;
                        if (fail_reg > {1'b0, cfg.retry_limit})
                        begin
                            fail_next   = '0;
                            active_next = QUERY_IDLE;
                            job.jkind   = JOB_FAIL;
                        end
                        else
                        begin
                            fail_next = fail_reg + FAIL_W'(1);
                        end
                    end
                end
                default:
                begin
                    job_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= QUERY_IDLE;
            count_reg  <= '0;
            fail_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
            fail_reg   <= fail_next;
        end
    end

    // The data bytes are always written in a frame before a decode reads them.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: hw/rtl/mprd_queue.sv
// ----------------------------------------------------------------------------
// mprd_queue
// Short job queue between the front and the back part.
// ----------------------------------------------------------------------------
module mprd_queue import mprd_pkg::*;
#(
    parameter int DEPTH = JOB_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/mprd_back.sv
// ----------------------------------------------------------------------------
// mprd_back
// Expands each job into its result items: a sequencer stage that decodes the
// excess-3 digits, then the output register (gain multiply if three-digit).
// ----------------------------------------------------------------------------
module mprd_back import mprd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    mprd_result_if.source result
);

    // Sequencer position inside the current job.
    logic [2:0]                 idx_reg, idx_next;

    logic                       s1_valid_reg;
    logic [KIND_W-1:0]          s1_kind_reg;
    logic [QUERY_W-1:0]         s1_query_reg;
    logic [CHANNEL_W-1:0]       s1_channel_reg;
    logic signed [RAW_W-1:0]    s1_raw_reg;
    logic                       s1_scale_reg;
    logic                       s1_last_reg;

    logic                       out_valid_reg;
    logic [KIND_W-1:0]          out_kind_reg;
    logic [QUERY_W-1:0]         out_query_reg;
    logic [CHANNEL_W-1:0]       out_channel_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic                       out_last_reg;

    logic                       out_load;
    logic                       s1_load;
    logic                       issue;
    logic                       three_digit;
    logic [2:0]                 n_values;
    logic [2:0]                 last_idx;
    logic [1:0]                 r;
    logic [DATA_IDX_W-1:0]      p2;
    logic [DATA_IDX_W-1:0]      p3;
    logic signed [RAW_W-1:0]    raw;
    logic [KIND_W-1:0]          d_kind;
    logic [QUERY_W-1:0]         d_query;
    logic [CHANNEL_W-1:0]       d_channel;
    logic signed [RAW_W-1:0]    d_raw;
    logic                       d_scale;
    logic signed [VALUE_W:0]    product;

    assign out_load  = !out_valid_reg || result.ready;
    assign s1_load   = !s1_valid_reg || out_load;
    assign issue     = job_valid && s1_load;

    // Voltage and current have three phase values, the others four.
    assign three_digit = (job.query != QUERY_VOLTAGE) && (job.query != QUERY_PF);
    assign n_values    = (job.query <= QUERY_CURRENT) ? 3'd3 : 3'd4;
    assign last_idx    = (job.jkind == JOB_FRAME) ? n_values : 3'd0;
    assign job_ready   = issue && (idx_reg == last_idx);

    assign r  = idx_reg[1:0];
    assign p2 = {1'b0, r, 1'b0};
    assign p3 = {2'b00, r} + {1'b0, r, 1'b0};

    always_comb
    begin
        if (three_digit)
        begin
            raw = byte_digit(job.data[p3 + DATA_IDX_W'(2)]) * RAW_W'(10000)
                + byte_digit(job.data[p3 + DATA_IDX_W'(1)]) * RAW_W'(100)
                + byte_digit(job.data[p3]);
        end
        else
        begin
            raw = byte_digit(job.data[p2 + DATA_IDX_W'(1)]) * RAW_W'(100)
                + byte_digit(job.data[p2]);
        end
    end

    always_comb
    begin
        d_kind    = KIND_REQUEST;
        d_query   = job.query;
        d_channel = '0;
        d_raw     = '0;
        d_scale   = 1'b0;
        case (job.jkind)
            JOB_REQUEST:
            begin
                d_kind = KIND_REQUEST;
            end
            JOB_FAIL:
            begin
                d_kind = KIND_FAILED;
            end
            JOB_FRAME:
            begin
                if (idx_reg < n_values)
                begin
                    d_kind    = KIND_VALUE;
                    d_channel = (job.query <= QUERY_CURRENT) ? r + CHANNEL_W'(1) : r;
                    d_raw     = raw;
                    d_scale   = three_digit;
                end
                else if (job.query == QUERY_PF)
                begin
                    d_kind  = KIND_DONE;
                    d_query = QUERY_PF;
                end
                else
                begin
                    d_kind  = KIND_REQUEST;
                    d_query = job.query + QUERY_W'(1);
                end
            end
            default:
            begin
                d_kind = KIND_REQUEST;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = (idx_reg == last_idx) ? 3'd0 : idx_reg + 3'd1;
        end
    end

    assign product = (VALUE_W+1)'(s1_raw_reg)
                   * (VALUE_W+1)'($signed({1'b0, cfg.current_scale}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (s1_load)
            begin
                s1_valid_reg <= issue;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_kind_reg    <= d_kind;
            s1_query_reg   <= d_query;
            s1_channel_reg <= d_channel;
            s1_raw_reg     <= d_raw;
            s1_scale_reg   <= d_scale;
            s1_last_reg    <= (idx_reg == last_idx);
        end
        if (out_load && s1_valid_reg)
        begin
            out_kind_reg    <= s1_kind_reg;
            out_query_reg   <= s1_query_reg;
            out_channel_reg <= s1_channel_reg;
            out_value_reg   <= s1_scale_reg ? product[VALUE_W-1:0] : VALUE_W'(s1_raw_reg);
            out_last_reg    <= s1_last_reg;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.kind    = out_kind_reg;
    assign result.query   = out_query_reg;
    assign result.channel = out_channel_reg;
    assign result.value   = out_value_reg;
    assign result.last    = out_last_reg;

endmodule

// File: hw/rtl/meter_poll_response_decoder.sv
// ----------------------------------------------------------------------------
// meter_poll_response_decoder
// Drives a six-step meter poll and decodes each response's excess-3 readings.
//
// The item channel takes a start, a received byte or a timeout. The result
// channel gives request items, measured values, cycle-done and cycle-failed,
// with last set on the final item caused by an input item. The cfg channel
// writes the current/power gain and the retry limit; it is always ready.
//
// Items are accepted one per cycle while the job queue has room. The front
// part handles each item in its accept cycle; its first result item then
// passes the job queue, sequencer and output registers. A completed frame
// produces four or five result items, one per cycle from the sequencer while
// the receiver takes them, holding the back part till the last. A start, or
// a timeout while a query is active, produces one item; others produce none.
// When the receiver stalls, the output register and sequencer hold, the
// queue fills and item.ready drops. Reset puts the poll sequence idle, clears
// the byte and failure counts, and loads the gain with 300 and the limit with 1.
// ----------------------------------------------------------------------------
module meter_poll_response_decoder import mprd_pkg::*;
#(
    parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    mprd_item_if.sink     item,
    mprd_result_if.source result,
    mprd_cfg_if.sink      cfg
);

    cfg_t cfg_reg;
    logic front_valid;
    logic front_ready;
    job_t front_job;
    logic back_valid;
    logic back_ready;
    job_t back_job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_scale <= SCALE_RESET;
            cfg_reg.retry_limit   <= RETRY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_CURRENT_SCALE: cfg_reg.current_scale <= cfg.data;
                CFG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg.data[RETRY_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    mprd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg_reg),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    mprd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    mprd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .result    (result)
    );

    // A done item only follows the power factor readings and ends the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_DONE |-> result.query == QUERY_PF && result.last)
        else $error("cycle-done with wrong query or without last");

    // Only measured values carry a value or a channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind != KIND_VALUE |-> result.value == '0 && result.channel == '0)
        else $error("non-value item carries value or channel");

    // Voltage and current readings are per phase, never total.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_VALUE && result.query <= QUERY_CURRENT
        |-> result.channel != '0)
        else $error("phase reading on total channel");

    // A measured value is never the final item of its input item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_VALUE |-> !result.last)
        else $error("measured value marked last");

endmodule
